FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, masked while rst_ni is low.
`define STCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define STCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/stcw_pkg.sv
// Package with the types, constants and sequencer states of the trie code walk.
package stcw_pkg;

  localparam int unsigned MAX_NODES      = 1048576;
  localparam int unsigned WORD_BUF_BYTES = 16777216;

  // Largest index a write can reach is set by the 20-bit node index field.
  localparam int unsigned INDEX_SPAN = 1048576;
  localparam int unsigned DEPTH_N    = (MAX_NODES < INDEX_SPAN) ? MAX_NODES : INDEX_SPAN;
  localparam int unsigned NODE_AW    = (DEPTH_N > 1) ? $clog2(DEPTH_N) : 1;

  localparam logic [24:0] MaxNodesW = 25'(MAX_NODES);
  localparam logic [20:0] DepthW    = 21'(DEPTH_N);

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic StatusFound    = 1'b0;
  localparam logic StatusNotFound = 1'b1;

  typedef logic [19:0] node_idx_t;
  typedef logic [20:0] code_t;
  typedef logic [20:0] range_t;

  typedef struct packed {
    logic        has;
    logic [23:0] offset;
  } word_t;

  typedef struct packed {
    code_t  chr;
    range_t first;
    range_t limit;
    word_t  words;
  } node_entry_t;

  typedef struct packed {
    logic        we;
    node_idx_t   waddr;
    node_entry_t wdata;
    logic        re;
    node_idx_t   raddr;
  } ram_req_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE,
    ST_LO,
    ST_HI,
    ST_PROBE,
    ST_CMP,
    ST_FIN,
    ST_WORD
  } state_e;

endpackage

FILE: rtl/core/stcw_node_ram.sv
// Node table memory: one write port and one registered read port.
module stcw_node_ram (
  input  logic                   clk_i,
  input  stcw_pkg::ram_req_t     req_i,
  output stcw_pkg::node_entry_t  rdata_o
);
  import stcw_pkg::*;

  node_entry_t mem [DEPTH_N];
  node_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[NODE_AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[NODE_AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/stcw_cmp.sv
// Shared magnitude comparator of the query code against a stored child code.
module stcw_cmp (
  input  stcw_pkg::code_t    code_i,
  input  stcw_pkg::code_t    pivot_i,
  output stcw_pkg::cmp_res_t res_o
);
  import stcw_pkg::*;

  always_comb begin
    res_o.lt = code_i < pivot_i;
    res_o.gt = code_i > pivot_i;
    res_o.eq = code_i == pivot_i;
  end

endmodule

FILE: rtl/core/stcw_ctrl.sv
// Sequencer and search registers that walk the trie one code at a time.
module stcw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  command_i,
  input  stcw_pkg::node_idx_t   node_index_i,
  input  stcw_pkg::code_t       node_char_i,
  input  stcw_pkg::range_t      child_first_i,
  input  stcw_pkg::range_t      child_limit_i,
  input  logic [23:0]           word_offset_i,
  input  logic                  has_words_i,
  input  stcw_pkg::code_t       query_code_i,
  input  logic                  query_last_i,
  output stcw_pkg::ram_req_t    ram_req_o,
  input  stcw_pkg::node_entry_t ram_rdata_i,
  output stcw_pkg::code_t       cmp_code_o,
  input  stcw_pkg::cmp_res_t    cmp_res_i,
  output logic                  done_o,
  output logic                  status_o,
  output stcw_pkg::node_idx_t   node_found_o,
  output logic [23:0]           word_offset_out_o,
  output logic                  has_words_out_o
);
  import stcw_pkg::*;

  state_e    state_q, state_d;
  node_idx_t cur_q, cur_d;
  logic      miss_q, miss_d;
  code_t     code_q, code_d;
  logic      last_q, last_d;
  range_t    lo_q, lo_d;
  range_t    hi_q, hi_d;
  node_idx_t mid_q, mid_d;
  logic      done_q, done_d;

  logic        status_q, status_d;
  node_idx_t   found_q, found_d;
  logic [23:0] offs_q, offs_d;
  logic        has_q, has_d;

  logic   accept;
  range_t lo_clip, hi_clip, mid_full, hi_minus;

  assign accept = start_i && (state_q == ST_IDLE);

  // Child ranges are clipped to the usable table size before the search.
  assign lo_clip  = (ram_rdata_i.first > DepthW) ? DepthW : ram_rdata_i.first;
  assign hi_clip  = (ram_rdata_i.limit > DepthW) ? DepthW : ram_rdata_i.limit;
  assign mid_full = lo_q + ((hi_q - lo_q) >> 1);
  assign hi_minus = hi_q - 21'd1;

  assign cmp_code_o = code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      miss_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      miss_q  <= miss_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    last_q   <= last_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    status_q <= status_d;
    found_q  <= found_d;
    offs_q   <= offs_d;
    has_q    <= has_d;
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    miss_d   = miss_q;
    code_d   = code_q;
    last_d   = last_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    done_d   = 1'b0;
    status_d = status_q;
    found_d  = found_q;
    offs_d   = offs_q;
    has_d    = has_q;

    ram_req_o.we          = 1'b0;
    ram_req_o.waddr       = node_index_i;
    ram_req_o.wdata.chr   = node_char_i;
    ram_req_o.wdata.first = child_first_i;
    ram_req_o.wdata.limit = child_limit_i;
    ram_req_o.wdata.words = '{has: has_words_i, offset: word_offset_i};
    ram_req_o.re          = 1'b0;
    ram_req_o.raddr       = cur_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CmdWrite) begin
            ram_req_o.we = {5'd0, node_index_i} < MaxNodesW;
          end else begin
            code_d = query_code_i;
            last_d = query_last_i;
            if (miss_q) begin
              state_d = ST_FIN;
            end else begin
              ram_req_o.re = 1'b1;
              state_d      = ST_NODE;
            end
          end
        end
      end
      ST_NODE: begin
        if (lo_clip >= hi_clip) begin
          miss_d  = 1'b1;
          state_d = ST_FIN;
        end else begin
          lo_d            = lo_clip;
          hi_d            = hi_clip;
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = lo_clip[19:0];
          state_d         = ST_LO;
        end
      end
      ST_LO: begin
        if (cmp_res_i.lt) begin
          miss_d  = 1'b1;
          state_d = ST_FIN;
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = hi_minus[19:0];
          state_d         = ST_HI;
        end
      end
      ST_HI: begin
        if (cmp_res_i.gt) begin
          miss_d  = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d           = mid_full[19:0];
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = mid_full[19:0];
          state_d         = ST_CMP;
        end else begin
          miss_d  = 1'b1;
          state_d = ST_FIN;
        end
      end
      ST_CMP: begin
        if (cmp_res_i.lt) begin
          hi_d    = {1'b0, mid_q};
          state_d = ST_PROBE;
        end else if (cmp_res_i.gt) begin
          lo_d    = {1'b0, mid_q} + 21'd1;
          state_d = ST_PROBE;
        end else if (cmp_res_i.eq) begin
          cur_d   = mid_q;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (miss_q) begin
          done_d   = 1'b1;
          status_d = StatusNotFound;
          found_d  = '0;
          offs_d   = '0;
          has_d    = 1'b0;
          cur_d    = '0;
          miss_d   = 1'b0;
          state_d  = ST_IDLE;
        end else begin
          ram_req_o.re = 1'b1;
          state_d      = ST_WORD;
        end
      end
      ST_WORD: begin
        done_d   = 1'b1;
        status_d = StatusFound;
        found_d  = cur_q;
        has_d    = ram_rdata_i.words.has;
        offs_d   = ram_rdata_i.words.has ? ram_rdata_i.words.offset : 24'd0;
        cur_d    = '0;
        miss_d   = 1'b0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o            = state_q != ST_IDLE;
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign node_found_o      = found_q;
  assign word_offset_out_o = offs_q;
  assign has_words_out_o   = has_q;

endmodule

FILE: rtl/core/static_trie_code_walk.sv
// Top level of the trie code walk: sequencer, shared comparator and node table.
// A new item is taken only in the idle state. A write needs no more; a code after a miss goes
// straight to the finish state, else the node is read, the child range bounds are checked and
// up to 21 binary search probes run. A found last code adds a word read, and the result strobe
// comes in the first idle cycle. The one registered table read port sets the pace.
// Reset clears the sequencer, the current node, the miss flag and the result strobe; the table is not cleared.
module static_trie_code_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                command_i,
  input  stcw_pkg::node_idx_t node_index_i,
  input  stcw_pkg::code_t     node_char_i,
  input  stcw_pkg::range_t    child_first_i,
  input  stcw_pkg::range_t    child_limit_i,
  input  logic [23:0]         word_offset_i,
  input  logic                has_words_i,
  input  stcw_pkg::code_t     query_code_i,
  input  logic                query_last_i,
  output logic                done_o,
  output logic                status_o,
  output stcw_pkg::node_idx_t node_found_o,
  output logic [23:0]         word_offset_out_o,
  output logic                has_words_out_o
);
  import stcw_pkg::*;

  ram_req_t    ram_req;
  node_entry_t ram_rdata;
  code_t       cmp_code;
  cmp_res_t    cmp_res;

  stcw_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_o            (busy),
    .command_i         (command_i),
    .node_index_i      (node_index_i),
    .node_char_i       (node_char_i),
    .child_first_i     (child_first_i),
    .child_limit_i     (child_limit_i),
    .word_offset_i     (word_offset_i),
    .has_words_i       (has_words_i),
    .query_code_i      (query_code_i),
    .query_last_i      (query_last_i),
    .ram_req_o         (ram_req),
    .ram_rdata_i       (ram_rdata),
    .cmp_code_o        (cmp_code),
    .cmp_res_i         (cmp_res),
    .done_o            (done_o),
    .status_o          (status_o),
    .node_found_o      (node_found_o),
    .word_offset_out_o (word_offset_out_o),
    .has_words_out_o   (has_words_out_o)
  );

  stcw_cmp u_cmp (
    .code_i  (cmp_code),
    .pivot_i (ram_rdata.chr),
    .res_o   (cmp_res)
  );

  stcw_node_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: rtl/core/stcw_checker.sv
// Port-level checker of the trie code walk and its bind to the top level.
`include "assert_macros.svh"

module stcw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                command_i,
  input logic                done_o,
  input logic                status_o,
  input stcw_pkg::node_idx_t node_found_o,
  input logic [23:0]         word_offset_out_o,
  input logic                has_words_out_o
);
  import stcw_pkg::*;

  // A result is only shown once its query transaction has fully finished.
  `STCW_ASSERT(a_done_idle, done_o |-> !busy, "result shown while busy")
  `STCW_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `STCW_ASSERT(a_miss_zero, (done_o && status_o == StatusNotFound) |-> (node_found_o == '0 && word_offset_out_o == '0 && !has_words_out_o), "not-found result carries data")
  `STCW_ASSERT(a_query_busy, (start && !busy && command_i == CmdQuery) |=> busy, "query transaction did not occupy the block")
  `STCW_ASSERT(a_write_quiet, (start && !busy && command_i == CmdWrite) |=> (!busy && !done_o), "write transaction disturbed the block")

endmodule

bind static_trie_code_walk stcw_checker u_stcw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .command_i         (command_i),
  .done_o            (done_o),
  .status_o          (status_o),
  .node_found_o      (node_found_o),
  .word_offset_out_o (word_offset_out_o),
  .has_words_out_o   (has_words_out_o)
);

FILE: tb/testbench.sv
// Self-checking testbench for the trie code walk: table loads, query walks and result checks.
module testbench;
  import stcw_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned PhaseItems = 250;
  localparam int unsigned SenderIdle[4] = '{0, 55, 0, 17};
  localparam range_t SpanEnd = 21'd1048576;
  localparam code_t CodeMax = 21'h10FFFF;

  typedef struct packed {
    logic        status;
    node_idx_t   node;
    logic [23:0] offset;
    logic        has;
  } walk_result_t;

  typedef struct {
    logic         command;
    node_idx_t    slot;
    code_t        chr;
    range_t       span_first;
    range_t       span_limit;
    logic [23:0]  offset;
    logic         has;
    code_t        code;
    logic         is_last;
    int unsigned  idle_pct;
    bit           drain;
    bit           emits;
    walk_result_t result;
  } trie_txn_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        command_i = 1'b0;
  node_idx_t   node_index_i = '0;
  code_t       node_char_i = '0;
  range_t      child_first_i = '0;
  range_t      child_limit_i = '0;
  logic [23:0] word_offset_i = '0;
  logic        has_words_i = 1'b0;
  code_t       query_code_i = '0;
  logic        query_last_i = 1'b0;
  logic        done_o;
  logic        status_o;
  node_idx_t   node_found_o;
  logic [23:0] word_offset_out_o;
  logic        has_words_out_o;

  static_trie_code_walk dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .node_index_i      (node_index_i),
    .node_char_i       (node_char_i),
    .child_first_i     (child_first_i),
    .child_limit_i     (child_limit_i),
    .word_offset_i     (word_offset_i),
    .has_words_i       (has_words_i),
    .query_code_i      (query_code_i),
    .query_last_i      (query_last_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .node_found_o      (node_found_o),
    .word_offset_out_o (word_offset_out_o),
    .has_words_out_o   (has_words_out_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow node table and walk state, advanced as the stimulus is generated.
  node_entry_t  trie_tab[node_idx_t];
  node_idx_t    walk_node = '0;
  bit           walk_missed = 1'b0;

  trie_txn_t    txn_q[$];
  walk_result_t pending_results[$];
  int unsigned  results_owed = 0;
  int unsigned  results_seen = 0;
  int unsigned  writes_done = 0;
  int unsigned  codes_done = 0;
  int unsigned  fail_cnt = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  gen_idle = 0;
  bit           gen_drain = 1'b0;
  int unsigned  items_made = 0;
  int unsigned  region_base = 0;
  int unsigned  region_size = 1;

  function automatic bit span_search(input range_t span_first, input range_t span_limit,
                                     input code_t code, output node_idx_t hit);
    range_t lo;
    range_t hi;
    range_t mid;
    code_t  pivot;
    hit = '0;
    lo = (span_first > DepthW) ? DepthW : span_first;
    hi = (span_limit > DepthW) ? DepthW : span_limit;
    if (lo >= hi) return 1'b0;
    if (code < trie_tab[node_idx_t'(lo)].chr || code > trie_tab[node_idx_t'(hi - 1)].chr)
      return 1'b0;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      pivot = trie_tab[node_idx_t'(mid)].chr;
      if (code < pivot) begin
        hi = mid;
      end else if (code > pivot) begin
        lo = mid + 21'd1;
      end else begin
        hit = node_idx_t'(mid);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void walk_code(input code_t code, input logic is_last,
                                    output bit emits, output walk_result_t res);
    node_idx_t   hit;
    node_entry_t e;
    emits = 1'b0;
    res = '0;
    if (!walk_missed) begin
      e = trie_tab[walk_node];
      if (span_search(e.first, e.limit, code, hit)) walk_node = hit;
      else walk_missed = 1'b1;
    end
    if (is_last) begin
      emits = 1'b1;
      if (walk_missed) begin
        res.status = StatusNotFound;
      end else begin
        e = trie_tab[walk_node];
        res.status = StatusFound;
        res.node = walk_node;
        res.offset = e.words.has ? e.words.offset : '0;
        res.has = e.words.has;
      end
      walk_node = '0;
      walk_missed = 1'b0;
    end
  endfunction

  function automatic trie_txn_t fresh_txn();
    trie_txn_t t;
    t.command = CmdQuery;
    t.slot = '0;
    t.chr = '0;
    t.span_first = '0;
    t.span_limit = '0;
    t.offset = '0;
    t.has = 1'b0;
    t.code = '0;
    t.is_last = 1'b0;
    t.idle_pct = gen_idle;
    t.drain = gen_drain;
    t.emits = 1'b0;
    t.result = '0;
    gen_drain = 1'b0;
    items_made++;
    return t;
  endfunction

  function automatic void queue_write(node_idx_t slot, code_t chr, range_t span_first,
                                      range_t span_limit, logic [23:0] offset, logic has);
    trie_txn_t   t;
    node_entry_t e;
    e.chr = chr;
    e.first = span_first;
    e.limit = span_limit;
    e.words.has = has;
    e.words.offset = offset;
    trie_tab[slot] = e;
    t = fresh_txn();
    t.command = CmdWrite;
    t.slot = slot;
    t.chr = chr;
    t.span_first = span_first;
    t.span_limit = span_limit;
    t.offset = offset;
    t.has = has;
    txn_q.push_back(t);
  endfunction

  function automatic void queue_code(code_t code, logic is_last);
    trie_txn_t t;
    t = fresh_txn();
    t.code = code;
    t.is_last = is_last;
    walk_code(code, is_last, t.emits, t.result);
    txn_q.push_back(t);
  endfunction

  // All four encodings end up as an empty range once clipped.
  function automatic void empty_span(output range_t span_first, output range_t span_limit);
    case ($urandom_range(3))
      0: begin
        span_first = range_t'($urandom_range(0, 1048576));
        span_limit = span_first;
      end
      1: begin
        span_first = SpanEnd;
        span_limit = '0;
      end
      2: begin
        span_first = SpanEnd;
        span_limit = SpanEnd;
      end
      default: begin
        span_limit = range_t'($urandom_range(0, 1048575));
        span_first = range_t'($urandom_range(int'(span_limit) + 1, 1048576));
      end
    endcase
  endfunction

  function automatic code_t pick_code(bit wide);
    if (wide) return code_t'($urandom_range(1, CodeMax));
    return code_t'($urandom_range(8'h61, 8'h7A));
  endfunction

  // Lays out a trie breadth first: root at entry 0, the rest contiguous from base.
  // Entries are written from the highest down, so every child range is loaded
  // before a node that points to it.
  function automatic void build_trie(int unsigned n, bit wide, bit scramble, bit at_top);
    code_t       chars[];
    range_t      firsts[];
    range_t      limits[];
    code_t       kids[$];
    code_t       cand;
    code_t       tmp;
    bit          dup;
    int unsigned next_free;
    int unsigned c;
    int unsigned base;
    int unsigned a;
    int unsigned b;
    chars = new[n];
    firsts = new[n];
    limits = new[n];
    base = at_top ? 1048577 - n : $urandom_range(1, 1048577 - n);
    chars[0] = code_t'($urandom_range(0, CodeMax));
    next_free = 1;
    for (int unsigned k = 0; k < n; k++) begin
      c = $urandom_range(0, 4);
      if (c > n - next_free) c = n - next_free;
      if (c == 0 && k + 1 == next_free && next_free < n) c = 1;
      if (c == 0) begin
        empty_span(firsts[k], limits[k]);
      end else begin
        kids.delete();
        while (kids.size() < c) begin
          cand = pick_code(wide);
          dup = 1'b0;
          foreach (kids[j]) if (kids[j] == cand) dup = 1'b1;
          if (!dup) kids.push_back(cand);
        end
        kids.sort();
        if (scramble && c > 1) begin
          a = $urandom_range(0, c - 1);
          b = $urandom_range(0, c - 1);
          tmp = kids[a];
          kids[a] = kids[b];
          kids[b] = tmp;
        end
        firsts[k] = range_t'(base + next_free - 1);
        limits[k] = range_t'(base + next_free - 1 + c);
        for (int unsigned j = 0; j < c; j++) chars[next_free + j] = kids[j];
        next_free += c;
      end
    end
    for (int k = int'(n) - 1; k >= 0; k--) begin
      queue_write((k == 0) ? node_idx_t'(0) : node_idx_t'(base + k - 1), chars[k], firsts[k],
                  limits[k], 24'($urandom()), 1'($urandom()));
    end
    region_base = base;
    region_size = n - 1;
  endfunction

  // Rewrites an entry while a query may be under way; the new child range is
  // either empty or lies inside the loaded region.
  function automatic void queue_noise_write();
    range_t      span_first;
    range_t      span_limit;
    node_idx_t   slot;
    int unsigned a;
    int unsigned b;
    if ($urandom_range(1)) slot = node_idx_t'(region_base + $urandom_range(0, region_size - 1));
    else slot = node_idx_t'($urandom_range(1, 1048575));
    if ($urandom_range(1)) begin
      empty_span(span_first, span_limit);
    end else begin
      a = $urandom_range(0, region_size - 1);
      b = $urandom_range(a, region_size);
      span_first = range_t'(region_base + a);
      span_limit = range_t'(region_base + b);
    end
    queue_write(slot, pick_code($urandom_range(1)), span_first, span_limit,
                24'($urandom()), 1'($urandom()));
  endfunction

  function automatic void queue_query(int unsigned len, bit broken);
    code_t       code;
    node_entry_t e;
    range_t      lo;
    range_t      hi;
    for (int unsigned s = 0; s < len; s++) begin
      if ($urandom_range(99) < 4) queue_noise_write();
      code = pick_code($urandom_range(1));
      if (!broken && !walk_missed && $urandom_range(99) < 85) begin
        e = trie_tab[walk_node];
        lo = (e.first > DepthW) ? DepthW : e.first;
        hi = (e.limit > DepthW) ? DepthW : e.limit;
        if (lo < hi) code = trie_tab[node_idx_t'($urandom_range(lo, hi - 1))].chr;
      end
      if (code == '0) code = code_t'(1);
      queue_code(code, s + 1 == len);
    end
  endfunction

  // Driver: presents the head of the queue and pops it when the block takes it.
  always @(posedge clk_i) begin
    bit fire;
    bit hold;
    if (rst_ni) begin
      fire = start && !busy;
      if (fire) begin
        if (txn_q[0].emits) begin
          pending_results.push_back(txn_q[0].result);
          results_owed++;
        end
        if (txn_q[0].command == CmdWrite) writes_done++;
        else codes_done++;
        void'(txn_q.pop_front());
      end
      if (!start || fire) begin
        // A result strobed in this cycle is counted here, since results_seen lags by one step.
        hold = txn_q.size() == 0 || $urandom_range(99) < txn_q[0].idle_pct
               || (txn_q[0].drain && results_owed != results_seen + 32'(done_o));
        start <= !hold;
        if (!hold) begin
          command_i <= txn_q[0].command;
          node_index_i <= txn_q[0].slot;
          node_char_i <= txn_q[0].chr;
          child_first_i <= txn_q[0].span_first;
          child_limit_i <= txn_q[0].span_limit;
          word_offset_i <= txn_q[0].offset;
          has_words_i <= txn_q[0].has;
          query_code_i <= txn_q[0].code;
          query_last_i <= txn_q[0].is_last;
        end
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest pending one.
  always @(posedge clk_i) begin
    walk_result_t want;
    if (rst_ni && done_o) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result with no query waiting: status %0d, node_found %0d",
               status_o, node_found_o);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_cnt++;
        end
        if (node_found_o !== want.node) begin
          $error("node_found: expected %0d, got %0d", want.node, node_found_o);
          fail_cnt++;
        end
        if (word_offset_out_o !== want.offset) begin
          $error("word_offset_out: expected %h, got %h", want.offset, word_offset_out_o);
          fail_cnt++;
        end
        if (has_words_out_o !== want.has) begin
          $error("has_words_out: expected %0d, got %0d", want.has, has_words_out_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves in either direction for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $error("no transaction for %0d cycles", QuietLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    gen_drain = 1'b1;
    // Small table at the top of the index space. The child range of 'a' ends
    // exactly at the table size and holds unsorted codes; the leaves use each
    // form of empty or inverted range.
    queue_write(20'd1048575, 21'h63, 21'd0, 21'd0, 24'h000001, 1'b1);
    queue_write(20'd1048574, 21'h0F0000, 21'd7, 21'd3, 24'h000000, 1'b0);
    queue_write(20'd1048573, 21'h62, 21'd5, 21'd5, 24'hABCDEF, 1'b1);
    queue_write(20'd1048572, CodeMax, SpanEnd, SpanEnd, 24'h000000, 1'b1);
    queue_write(20'd1048571, 21'h61, 21'd1048573, SpanEnd, 24'h123456, 1'b0);
    queue_write(20'd1048570, 21'h0, SpanEnd, 21'd0, 24'hFFFFFF, 1'b1);
    queue_write(20'd0, 21'h0, 21'd1048570, 21'd1048573, 24'hFFFFFF, 1'b1);
    queue_code(code_t'(0), 1'b1);
    queue_code(CodeMax, 1'b1);
    queue_code(21'h61, 1'b1);
    queue_code(21'h61, 1'b0);
    queue_code(21'h62, 1'b1);
    // Present in the range but rejected by the bounds check on unsorted children.
    queue_code(21'h61, 1'b0);
    queue_code(21'h0F0000, 1'b1);
    queue_code(21'h61, 1'b0);
    queue_code(21'h63, 1'b1);
    queue_code(CodeMax, 1'b0);
    queue_code(21'h62, 1'b1);
    // An early miss stays set even though the later code would be found.
    queue_code(21'h30, 1'b0);
    queue_code(21'h61, 1'b1);
    queue_code(21'h61, 1'b0);
    queue_code(21'h61, 1'b1);
    // Table rewrite in the middle of a query.
    queue_code(21'h61, 1'b0);
    queue_write(20'd1048574, 21'h65, 21'd9, 21'd2, 24'h0F0F0F, 1'b1);
    queue_code(21'h65, 1'b1);

    for (int p = 0; p < 4; p++) begin
      gen_idle = SenderIdle[p];
      gen_drain = 1'b1;
      while (items_made < (p + 1) * PhaseItems) begin
        build_trie($urandom_range(6, 30), $urandom_range(3) == 0, $urandom_range(9) == 0,
                   $urandom_range(5) == 0);
        repeat (12) queue_query($urandom_range(1, 7), $urandom_range(9) == 0);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (txn_q.size() != 0) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d table writes and %0d query codes, %0d walk results compared.",
             writes_done, codes_done, results_seen);
    $display("Sender idle rates of 0, 55, 0 and 17 percent, with a drain pause at each change.");
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
